// ===== hdl/fir_lowpass_primed_macros.svh =====
// ----------------------------------------------------------------------------
// fir_lowpass_primed assertion macros
// Clocked assertion shorthands for the filter's checker.
// ----------------------------------------------------------------------------
`ifndef FIR_LOWPASS_PRIMED_MACROS_SVH
`define FIR_LOWPASS_PRIMED_MACROS_SVH

// Checked only outside reset.
`define FLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked during reset too.
`define FLP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/fir_lp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_lp_pkg
// Constants, types and reset helpers shared by the low-pass FIR files.
// ----------------------------------------------------------------------------
package fir_lp_pkg;

  localparam int TAPS            = 14;
  localparam int HALF_TAPS       = TAPS / 2;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 16;
  localparam int CFG_IDX_BITS    = 3;

  // Renormalised low-pass weights, Q0.16, sum to one over all taps
  localparam int unsigned COEF_RST_Q16 [HALF_TAPS] = '{
    342, 3380, 3452, 4911, 6109, 7036, 7538
  };

  // Per-cell control from the top level
  typedef struct packed {
    logic shift;  // item accepted, move the line
    logic fill;   // first item after reset, load every cell
  } fir_lp_cell_ctl_t;

  // Reset weight rescaled to another coefficient width, round half up
  function automatic logic [31:0] coef_reset(input int idx, input int cb);
    logic [31:0] q;
    logic [31:0] half;
    q = 32'(COEF_RST_Q16[idx]);
    if (cb >= 16) begin
      coef_reset = q << (cb - 16);
    end else begin
      half       = (32'd1 << (16 - cb)) >> 1;
      coef_reset = (q + half) >> (16 - cb);
    end
  endfunction

endpackage

// ===== hdl/fir_lp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_lp_if
// Valid/ready channels of the low-pass FIR: samples, results, configuration.
// ----------------------------------------------------------------------------
interface fir_lp_sample_if import fir_lp_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface fir_lp_result_if import fir_lp_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered_out;

  modport source (output valid, output filtered_out, input ready);
  modport sink   (input valid, input filtered_out, output ready);
endinterface

interface fir_lp_cfg_if import fir_lp_pkg::*; #(
  parameter int COEF_BITS = COEF_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [COEF_BITS-1:0]    wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== hdl/fir_lp_tap_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_lp_tap_cell
// One history slot of the delay line; passes its sample on each shift.
// ----------------------------------------------------------------------------
module fir_lp_tap_cell import fir_lp_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  fir_lp_cell_ctl_t              ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] prev_i,
  output logic signed [SAMPLE_BITS-1:0] tap_o
);

  logic signed [SAMPLE_BITS-1:0] tap_q, tap_d;

  always_comb begin
    tap_d = tap_q;
    if (ctl_i.shift) begin
      tap_d = ctl_i.fill ? sample_i : prev_i;
    end
  end

  // payload only, primed logic covers the reset contents
  always_ff @(posedge clk_i) begin
    tap_q <= tap_d;
  end

  assign tap_o = tap_q;

endmodule

// ===== hdl/fir_lp_mac_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_lp_mac_lane
// Symmetric tap pair: registered pre-add, then registered product.
// ----------------------------------------------------------------------------
module fir_lp_mac_lane import fir_lp_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = COEF_BITS_DEF,
  localparam int PROD_BITS  = SAMPLE_BITS + COEF_BITS + 2
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [SAMPLE_BITS-1:0] tap_a_i,
  input  logic signed [SAMPLE_BITS-1:0] tap_b_i,
  input  logic        [COEF_BITS-1:0]   coef_i,
  output logic signed [PROD_BITS-1:0]   prod_o
);

  logic signed [SAMPLE_BITS:0]   pre_q, pre_d;
  logic signed [PROD_BITS-1:0]   prod_q, prod_d;
  logic signed [COEF_BITS:0]     coef_s;

  assign coef_s = $signed({1'b0, coef_i});
  assign pre_d  = (SAMPLE_BITS + 1)'(tap_a_i) + (SAMPLE_BITS + 1)'(tap_b_i);
  assign prod_d = PROD_BITS'(pre_q) * PROD_BITS'(coef_s);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_q  <= pre_d;
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== hdl/fir_lowpass_primed.sv =====
// Pipeline: delay line, pre-add, product, adder tree, output register.
// Throughput: one sample per cycle; the whole pipeline holds only while a
// finished result waits on result_o, set by the shared stage enable.
// Reset: asynchronous, active low; clears stage valids and the primed flag,
// and loads the coefficient registers with the renormalised low-pass set.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_lowpass_primed
// 14-tap symmetric low-pass FIR, tap-cell delay line and pair MAC lanes.
// ----------------------------------------------------------------------------
module fir_lowpass_primed import fir_lp_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = COEF_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  fir_lp_sample_if.sink    sample_i,
  fir_lp_result_if.source  result_o,
  fir_lp_cfg_if.sink       cfg_i
);

  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS + 2;
  localparam int ACC_BITS  = PROD_BITS + 3;
  // history, pre-add, product, three adder levels, output
  localparam int STAGES    = 7;

  localparam logic signed [ACC_BITS-1:0] RndHalf = ACC_BITS'(1) <<< (COEF_BITS - 1);
  localparam logic signed [ACC_BITS-1:0] SatHi   =
    ACC_BITS'($signed({1'b0, {(SAMPLE_BITS - 1){1'b1}}}));
  localparam logic signed [ACC_BITS-1:0] SatLo   =
    ACC_BITS'($signed({1'b1, {(SAMPLE_BITS - 1){1'b0}}}));

  // --------------------------------------------------------------------------
  // Flow control: everything advances together unless the output is stuck
  // --------------------------------------------------------------------------
  logic              en;
  logic              accept;
  logic [STAGES-1:0] vld_q, vld_d;
  logic              primed_q, primed_d;

  assign en             = !vld_q[STAGES-1] || result_o.ready;
  assign sample_i.ready = en;
  assign accept         = sample_i.valid && en;

  assign vld_d    = en ? {vld_q[STAGES-2:0], accept} : vld_q;
  assign primed_d = primed_q || accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      primed_q <= 1'b0;
    end else begin
      vld_q    <= vld_d;
      primed_q <= primed_d;
    end
  end

  // --------------------------------------------------------------------------
  // Coefficient registers; writes past the last index are dropped
  // --------------------------------------------------------------------------
  logic [COEF_BITS-1:0] coef_q [HALF_TAPS];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HALF_TAPS; i++) begin
        coef_q[i] <= COEF_BITS'(coef_reset(i, COEF_BITS));
      end
    end else if (cfg_i.valid && (cfg_i.index < CFG_IDX_BITS'(HALF_TAPS))) begin
      coef_q[cfg_i.index] <= cfg_i.wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Delay line: tap 0 newest. First item after reset fills every cell.
  // --------------------------------------------------------------------------
  fir_lp_cell_ctl_t              cell_ctl;
  logic signed [SAMPLE_BITS-1:0] tap [TAPS];

  assign cell_ctl.shift = accept;
  assign cell_ctl.fill  = !primed_q;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    if (k == 0) begin : g_head
      fir_lp_tap_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk_i    (clk_i),
        .ctl_i    (cell_ctl),
        .sample_i (sample_i.sample_in),
        .prev_i   (sample_i.sample_in),
        .tap_o    (tap[k])
      );
    end else begin : g_body
      fir_lp_tap_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk_i    (clk_i),
        .ctl_i    (cell_ctl),
        .sample_i (sample_i.sample_in),
        .prev_i   (tap[k-1]),
        .tap_o    (tap[k])
      );
    end
  end

  // --------------------------------------------------------------------------
  // Pair lanes: tap m and tap 13-m share coefficient m
  // --------------------------------------------------------------------------
  logic signed [PROD_BITS-1:0] prod [HALF_TAPS];

  for (genvar m = 0; m < HALF_TAPS; m++) begin : g_lane
    fir_lp_mac_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .tap_a_i (tap[m]),
      .tap_b_i (tap[TAPS-1-m]),
      .coef_i  (coef_q[m]),
      .prod_o  (prod[m])
    );
  end

  // --------------------------------------------------------------------------
  // Adder tree over the seven products, exact width
  // --------------------------------------------------------------------------
  logic signed [ACC_BITS-1:0] s1_q [4];
  logic signed [ACC_BITS-1:0] s2_q [2];
  logic signed [ACC_BITS-1:0] s3_q;
  logic signed [ACC_BITS-1:0] s1_d [4];
  logic signed [ACC_BITS-1:0] s2_d [2];
  logic signed [ACC_BITS-1:0] s3_d;

  always_comb begin
    s1_d[0] = ACC_BITS'(prod[0]) + ACC_BITS'(prod[1]);
    s1_d[1] = ACC_BITS'(prod[2]) + ACC_BITS'(prod[3]);
    s1_d[2] = ACC_BITS'(prod[4]) + ACC_BITS'(prod[5]);
    s1_d[3] = ACC_BITS'(prod[6]);
    s2_d[0] = s1_q[0] + s1_q[1];
    s2_d[1] = s1_q[2] + s1_q[3];
    s3_d    = s2_q[0] + s2_q[1];
  end

  // --------------------------------------------------------------------------
  // Round half up, floor shift, saturate to the sample range
  // --------------------------------------------------------------------------
  logic signed [ACC_BITS-1:0]    rnd;
  logic signed [ACC_BITS-1:0]    shr;
  logic signed [SAMPLE_BITS-1:0] out_q, out_d;

  always_comb begin
    rnd = s3_q + RndHalf;
    shr = rnd >>> COEF_BITS;
    if (shr > SatHi) begin
      out_d = SatHi[SAMPLE_BITS-1:0];
    end else if (shr < SatLo) begin
      out_d = SatLo[SAMPLE_BITS-1:0];
    end else begin
      out_d = shr[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      out_q <= out_d;
    end
  end

  assign result_o.valid        = vld_q[STAGES-1];
  assign result_o.filtered_out = out_q;

endmodule

// ===== hdl/fir_lp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_lp_checker
// Port-level checks on the low-pass FIR, bound to the top level.
// ----------------------------------------------------------------------------
`include "fir_lowpass_primed_macros.svh"

module fir_lp_checker import fir_lp_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_data,
  input logic                   cfg_ready
);

  logic stall;

  assign stall = out_valid && !out_ready;

  // stalled result holds
  `FLP_ASSERT(a_out_hold, stall |=> out_valid && $stable(out_data), "stalled result moved")

  // input only back-pressured by a waiting result
  `FLP_ASSERT(a_in_ready, in_ready == !stall, "input ready not tied to stall")

  // config port never stalls
  `FLP_ASSERT(a_cfg_ready, cfg_ready, "config port not ready")

  // no result offered after reset is sampled low
  `FLP_ASSERT_RST(a_rst_quiet, !rst_ni |=> !out_valid, "result valid during reset")

endmodule

bind fir_lowpass_primed fir_lp_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_fir_lp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (sample_i.ready),
  .out_valid (result_o.valid),
  .out_ready (result_o.ready),
  .out_data  (result_o.filtered_out),
  .cfg_ready (cfg_i.ready)
);

// ===== tb/sv/fir_lowpass_primed_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_lowpass_primed_chk
// Passive checker: watches the sample, result and config channels, keeps its
// own filter state, predicts each filtered item and compares it in order.
// ----------------------------------------------------------------------------
module fir_lowpass_primed_chk import fir_lp_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = COEF_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fir_lp_sample_if    smp_i,
  fir_lp_result_if    res_i,
  fir_lp_cfg_if       cfg_i,
  output int unsigned pending_o,
  output int unsigned fails_o
);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam longint SAT_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam longint SAT_LO = -SAT_HI - 64'sd1;
  localparam longint HALF_LSB = 64'sd1 <<< (COEF_BITS - 1);

  logic [COEF_BITS-1:0] weight [HALF_TAPS];
  sample_t              delay_line [TAPS];
  logic                 filled;
  sample_t              filt_due [$];
  sample_t              due_v;
  int unsigned          errs;

  // One filter step: shift the line (first item fills it), weighted sum,
  // round half up, clamp to the sample range.
  function automatic sample_t filter_step(input sample_t s);
    longint acc;
    longint y;
    int     m;
    if (!filled) begin
      for (int k = 0; k < TAPS; k++) delay_line[k] = s;
      filled = 1'b1;
    end
    for (int k = TAPS - 1; k > 0; k--) delay_line[k] = delay_line[k-1];
    delay_line[0] = s;
    acc = 0;
    for (int k = 0; k < TAPS; k++) begin
      m   = (k < HALF_TAPS) ? k : TAPS - 1 - k;
      acc = acc + longint'(weight[m]) * longint'(delay_line[k]);
    end
    y = (acc + HALF_LSB) >>> COEF_BITS;
    if (y > SAT_HI) y = SAT_HI;
    if (y < SAT_LO) y = SAT_LO;
    return sample_t'(y);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HALF_TAPS; i++) weight[i] = COEF_BITS'(coef_reset(i, COEF_BITS));
      for (int k = 0; k < TAPS; k++) delay_line[k] = '0;
      filled = 1'b0;
      filt_due.delete();
      errs = 0;
    end else begin
      // result first: a result never belongs to a sample accepted on the same edge
      if (res_i.valid && res_i.ready) begin
        if (filt_due.size() == 0) begin
          errs++;
          $display("%0t: filtered_out expected none, actual %0d", $time,
                   res_i.filtered_out);
        end else begin
          due_v = filt_due.pop_front();
          if (res_i.filtered_out !== due_v) begin
            errs++;
            $display("%0t: filtered_out expected %0d, actual %0d", $time,
                     due_v, res_i.filtered_out);
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready && cfg_i.index < HALF_TAPS)
        weight[cfg_i.index] = cfg_i.wdata;
      if (smp_i.valid && smp_i.ready)
        filt_due = {filt_due, filter_step(smp_i.sample_in)};
    end
    pending_o <= filt_due.size();
    fails_o   <= errs;
  end

endmodule

// ===== tb/sv/fir_lowpass_primed_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_lowpass_primed_tb
// Regression for the 14-tap low-pass FIR: directed extremes and saturation,
// then random weight sets and sample streams under random source and sink
// stalls; a side checker predicts and compares every filtered item.
// ----------------------------------------------------------------------------
module fir_lowpass_primed_tb;
  import fir_lp_pkg::*;

  localparam int SB          = SAMPLE_BITS_DEF;
  localparam int CB          = COEF_BITS_DEF;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 235;
  localparam int SETTLE      = 12;      // margin past the pipeline depth
  localparam int LIMIT       = 200000;  // watchdog limit

  // index past the last weight: writes to it must be dropped
  localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE = CFG_IDX_BITS'(HALF_TAPS);

  typedef logic signed [SB-1:0] sample_t;

  localparam sample_t       S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam sample_t       S_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic [CB-1:0] W_MAX = '1;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  fir_lp_sample_if #(.SAMPLE_BITS(SB)) smp_if ();
  fir_lp_result_if #(.SAMPLE_BITS(SB)) res_if ();
  fir_lp_cfg_if    #(.COEF_BITS(CB))   cfg_if ();

  int unsigned   pending;
  int unsigned   fails;
  int unsigned   cycles = 0;
  int unsigned   res_hold;
  bit            calm;          // no idling on either side while set
  sample_t       ramp_v;        // slowly wandering signal for smooth runs
  logic [CB-1:0] wset [HALF_TAPS];
  int unsigned   wmode;

  fir_lowpass_primed u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  fir_lowpass_primed_chk #(
    .SAMPLE_BITS (SB),
    .COEF_BITS   (CB)
  ) u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .smp_i     (smp_if),
    .res_i     (res_if),
    .cfg_i     (cfg_if),
    .pending_o (pending),
    .fails_o   (fails)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake or a lost item ends here
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("fir_lowpass_primed regression: fail");
      $finish;
    end
  end

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  // Result sink: after each accepted item, drop ready for a drawn number of
  // cycles; the stall also lands while nothing is offered.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      res_hold = 0;
    end else if (res_if.valid && res_if.ready) begin
      res_hold = draw_wait();
      res_if.ready <= (res_hold == 0);
    end else if (res_hold > 0) begin
      res_hold--;
      res_if.ready <= (res_hold == 0);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Offer one sample; valid stays high straight into the next item when no
  // gap is drawn, so it is never lowered and raised in one step.
  task automatic send_sample(input sample_t v);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp_if.valid     <= 1'b1;
    smp_if.sample_in <= v;
    do @(posedge clk_i); while (!smp_if.ready);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [CB-1:0] d);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      cfg_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // Write the whole weight set, sometimes with a stray write to the spare
  // index slipped in; block is idle whenever this runs.
  task automatic load_weights(input bit spare);
    for (int i = 0; i < HALF_TAPS; i++) begin
      if (spare && i == 3) cfg_write(IDX_SPARE, CB'($urandom));
      cfg_write(CFG_IDX_BITS'(i), wset[i]);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Stop offering, then wait for every expected item plus pipeline margin
  task automatic drain();
    smp_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Mostly full-range noise, plus rails, near-zero values and a wandering
  // ramp so the history holds correlated data as well.
  function automatic sample_t next_sample();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? S_MAX : S_MIN;
      1, 2: return sample_t'(int'($urandom_range(0, 2000)) - 1000);
      3, 4: begin
        ramp_v = ramp_v + sample_t'(int'($urandom_range(0, 131071)) - 65536);
        return ramp_v;
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  initial begin
    smp_if.valid     = 1'b0;
    smp_if.sample_in = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.wdata     = '0;
    res_if.ready     = 1'b0;
    calm             = 1'b0;
    ramp_v           = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset weights. The very first item primes the whole line with the
    // most negative value; the unity-gain set must pass it through exactly.
    send_sample(S_MIN);
    send_sample(S_MAX);
    send_sample('0);
    send_sample(-sample_t'(1));
    send_sample(sample_t'(1));
    send_sample(sample_t'(24'h555555));
    send_sample(sample_t'(24'hAAAAAA));
    send_sample(S_MAX);
    send_sample(S_MAX);
    send_sample(S_MIN);
    drain();

    // All weights at full scale: gain ~14, rails in both directions.
    // The stray spare-index write must not disturb anything.
    for (int i = 0; i < HALF_TAPS; i++) wset[i] = W_MAX;
    load_weights(1'b1);
    send_sample(S_MAX);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(S_MIN);
    send_sample('0);
    send_sample(-sample_t'(1));
    drain();

    // All weights zero: output is just the rounding of zero
    for (int i = 0; i < HALF_TAPS; i++) wset[i] = '0;
    load_weights(1'b0);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(sample_t'(1));
    drain();

    // Random part: a new weight set per phase, then a long sample stream.
    // Calm stretches with no idling are drawn at every 40th item, one chance in four.
    for (int p = 0; p < PHASES; p++) begin
      wmode = $urandom_range(0, 4);
      for (int i = 0; i < HALF_TAPS; i++) begin
        case (wmode)
          0: wset[i] = CB'(COEF_RST_Q16[i]);
          1: wset[i] = W_MAX;
          2: wset[i] = CB'($urandom);
          3: wset[i] = CB'($urandom_range(0, 9362));   // gain up to ~2
          default: begin
            case ($urandom_range(0, 2))
              0: wset[i] = '0;
              1: wset[i] = W_MAX;
              default: wset[i] = CB'($urandom);
            endcase
          end
        endcase
      end
      calm = 1'b0;
      load_weights(1'($urandom_range(0, 1)));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        send_sample(next_sample());
      end
      drain();
    end

    if (fails == 0) begin
      $display("fir_lowpass_primed regression: pass");
    end else begin
      $display("fir_lowpass_primed regression: fail");
    end
    $finish;
  end

endmodule
